// ----- rtl/wsfr_pkg.sv -----
package wsfr_pkg;

	localparam int DATA_W     = 8;
	localparam int LEN_W      = 63;
	localparam int ACC_W      = 64;
	localparam int KEY_W      = 32;
	localparam int CTRL_LIM_W = 7;
	localparam int OPCODE_W   = 4;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 63;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_KEY,
		PH_DATA
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	localparam logic ERR_PROTOCOL = 1'b0;
	localparam logic ERR_TOO_BIG  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_LIMIT = 2'd1;

	localparam logic [OPCODE_W-1:0] OP_CONT   = 4'h0;
	localparam logic [OPCODE_W-1:0] OP_TEXT   = 4'h1;
	localparam logic [OPCODE_W-1:0] OP_BINARY = 4'h2;
	localparam logic [OPCODE_W-1:0] OP_CLOSE  = 4'h8;
	localparam logic [OPCODE_W-1:0] OP_PING   = 4'h9;
	localparam logic [OPCODE_W-1:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	localparam logic [CFG_DATA_W-1:0] MAX_FRAME_LEN_RST = 63'd1048576;
	localparam logic [CTRL_LIM_W-1:0] CONTROL_LIMIT_RST = 7'd125;

	typedef struct packed {
		logic [LEN_W-1:0]      max_frame_len;
		logic [CTRL_LIM_W-1:0] control_limit;
	} cfg_t;

	typedef struct packed {
		kind_t               out_kind;
		logic                fin;
		logic [OPCODE_W-1:0] opcode;
		logic [LEN_W-1:0]    payload_length;
		logic [DATA_W-1:0]   data_out;
		logic                last_of_frame;
		logic                error_code;
	} result_t;

endpackage

// ----- rtl/wsfr_byte_if.sv -----
interface wsfr_byte_if import wsfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ----- rtl/wsfr_result_if.sv -----
interface wsfr_result_if import wsfr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   out_kind;
	logic                fin;
	logic [OPCODE_W-1:0] opcode;
	logic [LEN_W-1:0]    payload_length;
	logic [DATA_W-1:0]   data_out;
	logic                last_of_frame;
	logic                error_code;

	modport source (output valid, output out_kind, output fin, output opcode,
		output payload_length, output data_out, output last_of_frame,
		output error_code, input ready);
	modport sink (input valid, input out_kind, input fin, input opcode,
		input payload_length, input data_out, input last_of_frame,
		input error_code, output ready);
endinterface

// ----- rtl/wsfr_parser.sv -----
module wsfr_parser import wsfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [DATA_W-1:0] data_byte,
	input  cfg_t              cfg,
	output logic              res_valid,
	output result_t           res
);

	phase_t                phase_q, phase_d;
	logic                  fin_q, fin_d;
	logic [OPCODE_W-1:0]   opcode_q, opcode_d;
	logic [3:0]            ext_left_q, ext_left_d;
	logic [ACC_W-1:0]      length_acc_q, length_acc_d;
	logic [KEY_W-1:0]      mask_key_q, mask_key_d;
	logic [2:0]            key_left_q, key_left_d;
	logic [1:0]            mask_phase_q, mask_phase_d;
	logic [LEN_W-1:0]      remaining_q, remaining_d;
	logic                  failed_q, failed_d;
	logic                  fail_code_q, fail_code_d;

	logic [6:0]            len7;
	logic [ACC_W-1:0]      acc_ext;
	logic [3:0]            ext_dec;
	logic [2:0]            key_dec;
	logic [LEN_W-1:0]      rem_dec;
	logic [ACC_W-1:0]      chk_acc;
	logic                  too_big;
	logic                  op_known;
	logic [1:0]            key_sel;
	logic [DATA_W-1:0]     key_byte;
	logic                  err_hit;
	logic                  err_code;

	assign len7     = data_byte[6:0];
	assign acc_ext  = {length_acc_q[ACC_W-DATA_W-1:0], data_byte};
	assign ext_dec  = ext_left_q - 4'd1;
	assign key_dec  = key_left_q - 3'd1;
	assign rem_dec  = (remaining_q != '0) ? remaining_q - LEN_W'(1) : remaining_q;
	assign chk_acc  = (phase_q == PH_HDR1) ? {{(ACC_W-7){1'b0}}, len7} : acc_ext;
	assign too_big  = chk_acc[LEN_W-1:0] > cfg.max_frame_len;
	assign op_known = (data_byte[3:0] == OP_CONT) || (data_byte[3:0] == OP_TEXT) ||
		(data_byte[3:0] == OP_BINARY) || (data_byte[3:0] == OP_CLOSE) ||
		(data_byte[3:0] == OP_PING) || (data_byte[3:0] == OP_PONG);
	// key byte 0 (first received) masks payload byte 0
	assign key_sel  = 2'd3 - mask_phase_q;
	assign key_byte = mask_key_q[{key_sel, 3'b000} +: DATA_W];

	// fault detection on the current byte
	always_comb begin
		err_hit  = 1'b0;
		err_code = ERR_PROTOCOL;
		case (phase_q)
			PH_HDR0: begin
				if (data_byte[6:4] != 3'd0 || !op_known || (data_byte[3] && !data_byte[7]))
					err_hit = 1'b1;
			end
			PH_HDR1: begin
				// control length is checked ahead of the mask bit
				if ((opcode_q[3] && len7 > cfg.control_limit) || !data_byte[7]) begin
					err_hit = 1'b1;
				end else if (len7 != LEN7_EXT16 && len7 != LEN7_EXT64 && too_big) begin
					err_hit  = 1'b1;
					err_code = ERR_TOO_BIG;
				end
			end
			PH_EXT: begin
				if (ext_dec == 4'd0) begin
					if (chk_acc[ACC_W-1]) begin
						err_hit = 1'b1;
					end else if (too_big) begin
						err_hit  = 1'b1;
						err_code = ERR_TOO_BIG;
					end
				end
			end
			default: begin
				err_hit = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		phase_d      = phase_q;
		fin_d        = fin_q;
		opcode_d     = opcode_q;
		ext_left_d   = ext_left_q;
		length_acc_d = length_acc_q;
		mask_key_d   = mask_key_q;
		key_left_d   = key_left_q;
		mask_phase_d = mask_phase_q;
		remaining_d  = remaining_q;
		failed_d     = failed_q;
		fail_code_d  = fail_code_q;
		if (!failed_q && err_hit) begin
			failed_d    = 1'b1;
			fail_code_d = err_code;
		end else if (!failed_q) begin
			case (phase_q)
				PH_HDR0: begin
					fin_d    = data_byte[7];
					opcode_d = data_byte[3:0];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					if (len7 == LEN7_EXT16) begin
						length_acc_d = '0;
						ext_left_d   = EXT16_BYTES;
						phase_d      = PH_EXT;
					end else if (len7 == LEN7_EXT64) begin
						length_acc_d = '0;
						ext_left_d   = EXT64_BYTES;
						phase_d      = PH_EXT;
					end else begin
						length_acc_d = chk_acc;
						key_left_d   = KEY_BYTES;
						mask_key_d   = '0;
						phase_d      = PH_KEY;
					end
				end
				PH_EXT: begin
					length_acc_d = acc_ext;
					ext_left_d   = ext_dec;
					if (ext_dec == 4'd0) begin
						key_left_d = KEY_BYTES;
						mask_key_d = '0;
						phase_d    = PH_KEY;
					end
				end
				PH_KEY: begin
					mask_key_d = {mask_key_q[KEY_W-DATA_W-1:0], data_byte};
					key_left_d = key_dec;
					if (key_dec == 3'd0) begin
						remaining_d  = length_acc_q[LEN_W-1:0];
						mask_phase_d = 2'd0;
						phase_d      = (length_acc_q == '0) ? PH_HDR0 : PH_DATA;
					end
				end
				PH_DATA: begin
					mask_phase_d = mask_phase_q + 2'd1;
					remaining_d  = rem_dec;
					if (rem_dec == '0)
						phase_d = PH_HDR0;
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
		end
	end

	// result word
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (failed_q || err_hit) begin
			res_valid      = 1'b1;
			res.out_kind   = KIND_ERROR;
			res.error_code = failed_q ? fail_code_q : err_code;
		end else begin
			case (phase_q)
				PH_KEY: begin
					if (key_dec == 3'd0) begin
						res_valid          = 1'b1;
						res.out_kind       = KIND_HEADER;
						res.fin            = fin_q;
						res.opcode         = opcode_q;
						res.payload_length = length_acc_q[LEN_W-1:0];
						res.last_of_frame  = (length_acc_q == '0);
					end
				end
				PH_DATA: begin
					res_valid          = 1'b1;
					res.out_kind       = KIND_PAYLOAD;
					res.fin            = fin_q;
					res.opcode         = opcode_q;
					res.payload_length = length_acc_q[LEN_W-1:0];
					res.data_out       = data_byte ^ key_byte;
					res.last_of_frame  = (rem_dec == '0);
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			fin_q        <= 1'b0;
			opcode_q     <= '0;
			ext_left_q   <= '0;
			length_acc_q <= '0;
			mask_key_q   <= '0;
			key_left_q   <= '0;
			mask_phase_q <= '0;
			remaining_q  <= '0;
			failed_q     <= 1'b0;
			fail_code_q  <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			fin_q        <= fin_d;
			opcode_q     <= opcode_d;
			ext_left_q   <= ext_left_d;
			length_acc_q <= length_acc_d;
			mask_key_q   <= mask_key_d;
			key_left_q   <= key_left_d;
			mask_phase_q <= mask_phase_d;
			remaining_q  <= remaining_d;
			failed_q     <= failed_d;
			fail_code_q  <= fail_code_d;
		end
	end

endmodule

// ----- rtl/websocket_frame_receiver_unit.sv -----
// channel       | dir | word                      | payload
// frame_bytes   | in  | one received stream byte  | data_byte
// results       | out | header, payload or error  | out_kind, fin, opcode, payload_length,
//               |     |                           | data_out, last_of_frame, error_code
// config write  | in  | write_en/reg_index/write_data, no read-back
//
// One byte per cycle sustained while results does not stall. A byte is held
// in the input register, is parsed against the frame state and lands in the
// result register. arst_n clears the frame state and the sticky failure and
// resets the config registers (max 1048576, control limit 125).
// When results stalls, the input register holds its byte and frame_bytes.ready
// drops once that register is full.
module websocket_frame_receiver_unit import wsfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	wsfr_byte_if.sink             frame_bytes,
	wsfr_result_if.source         results,
	input  logic                  write_en,
	input  logic [CFG_IDX_W-1:0]  reg_index,
	input  logic [CFG_DATA_W-1:0] write_data
);

	logic              byte_vld_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              res_vld_q;
	result_t           res_q;
	cfg_t              cfg_q;
	logic              out_free;
	logic              advance;
	logic              res_valid;
	result_t           res;

	assign out_free          = !res_vld_q || results.ready;
	assign advance           = byte_vld_s1 && out_free;
	assign frame_bytes.ready = !byte_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_len <= MAX_FRAME_LEN_RST;
			cfg_q.control_limit <= CONTROL_LIMIT_RST;
		end else if (write_en) begin
			case (reg_index)
				CFG_MAX_FRAME_LEN: cfg_q.max_frame_len <= write_data[LEN_W-1:0];
				CFG_CONTROL_LIMIT: cfg_q.control_limit <= write_data[CTRL_LIM_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (frame_bytes.valid && frame_bytes.ready) begin
			byte_vld_s1 <= 1'b1;
		end else if (advance) begin
			byte_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_bytes.valid && frame_bytes.ready)
			byte_s1 <= frame_bytes.data_byte;
	end

	wsfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance && res_valid) begin
			res_vld_q <= 1'b1;
		end else if (results.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			res_q <= res;
	end

	assign results.valid          = res_vld_q;
	assign results.out_kind       = res_q.out_kind;
	assign results.fin            = res_q.fin;
	assign results.opcode         = res_q.opcode;
	assign results.payload_length = res_q.payload_length;
	assign results.data_out       = res_q.data_out;
	assign results.last_of_frame  = res_q.last_of_frame;
	assign results.error_code     = res_q.error_code;

endmodule

// ----- tb/testbench.sv -----
module testbench import wsfr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_TAIL  = 6;

	typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_enc_t;
	typedef enum {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} pressure_t;
	typedef enum {F_RESERVED, F_OPCODE, F_FRAG_CTRL, F_CTRL_LEN, F_NO_MASK, F_HUGE,
		F_TOO_BIG} fault_t;

	class frame_scoreboard;
		result_t pending_results[$];
		int mismatches;

		logic [LEN_W-1:0]      max_len;
		logic [CTRL_LIM_W-1:0] ctrl_lim;

		phase_t              ph;
		logic                fin_q;
		logic [OPCODE_W-1:0] op_q;
		logic [3:0]          ext_left;
		logic [ACC_W-1:0]    len_acc;
		logic [KEY_W-1:0]    key;
		logic [2:0]          key_left;
		logic [1:0]          key_pos;
		logic [LEN_W-1:0]    remaining;
		logic                failed;
		logic                fail_code;

		function new();
			max_len = MAX_FRAME_LEN_RST;
			ctrl_lim = CONTROL_LIMIT_RST;
			ph = PH_HDR0;
			fin_q = 1'b0;
			op_q = '0;
			ext_left = '0;
			len_acc = '0;
			key = '0;
			key_left = '0;
			key_pos = '0;
			remaining = '0;
			failed = 1'b0;
			fail_code = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_MAX_FRAME_LEN)
				max_len = val;
			else if (idx == CFG_CONTROL_LIMIT)
				ctrl_lim = val[CTRL_LIM_W-1:0];
		endfunction

		function bit op_known(logic [OPCODE_W-1:0] op);
			case (op)
				OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		// failure is sticky: every later byte repeats this code
		function void fault(logic code);
			result_t r;
			r = '0;
			failed = 1'b1;
			fail_code = code;
			r.out_kind = KIND_ERROR;
			r.error_code = code;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void close_length();
			if (len_acc[ACC_W-1])
				fault(ERR_PROTOCOL);
			else if (len_acc[LEN_W-1:0] > max_len)
				fault(ERR_TOO_BIG);
			else begin
				key_left = KEY_BYTES;
				key = '0;
				ph = PH_KEY;
			end
		endfunction

		function void deframe_byte(logic [DATA_W-1:0] b);
			result_t r;
			logic [6:0] len7;
			r = '0;
			len7 = b[6:0];
			if (failed) begin
				fault(fail_code);
				return;
			end
			case (ph)
				PH_HDR1: begin
					if (op_q[3] && len7 > ctrl_lim)
						fault(ERR_PROTOCOL);
					else if (!b[7])
						fault(ERR_PROTOCOL);
					else begin
						len_acc = '0;
						if (len7 == LEN7_EXT16) begin
							ext_left = EXT16_BYTES;
							ph = PH_EXT;
						end else if (len7 == LEN7_EXT64) begin
							ext_left = EXT64_BYTES;
							ph = PH_EXT;
						end else begin
							len_acc = {57'd0, len7};
							close_length();
						end
					end
				end
				PH_EXT: begin
					len_acc = {len_acc[ACC_W-9:0], b};
					ext_left = ext_left - 4'd1;
					if (ext_left == 4'd0)
						close_length();
				end
				PH_KEY: begin
					key = {key[KEY_W-9:0], b};
					key_left = key_left - 3'd1;
					if (key_left == 3'd0) begin
						r.out_kind = KIND_HEADER;
						r.fin = fin_q;
						r.opcode = op_q;
						r.payload_length = len_acc[LEN_W-1:0];
						r.last_of_frame = (len_acc == '0);
						pending_results.insert(pending_results.size(), r);
						remaining = len_acc[LEN_W-1:0];
						key_pos = 2'd0;
						ph = (len_acc == '0) ? PH_HDR0 : PH_DATA;
					end
				end
				PH_DATA: begin
					// first key byte masks payload byte 0
					r.out_kind = KIND_PAYLOAD;
					r.fin = fin_q;
					r.opcode = op_q;
					r.payload_length = len_acc[LEN_W-1:0];
					r.data_out = b ^ key[8*(3-int'(key_pos)) +: 8];
					key_pos = key_pos + 2'd1;
					if (remaining != '0)
						remaining = remaining - 63'd1;
					if (remaining == '0) begin
						r.last_of_frame = 1'b1;
						ph = PH_HDR0;
					end
					pending_results.insert(pending_results.size(), r);
				end
				default: begin
					if (b[6:4] != 3'b000)
						fault(ERR_PROTOCOL);
					else begin
						fin_q = b[7];
						op_q = b[3:0];
						if (!op_known(op_q))
							fault(ERR_PROTOCOL);
						else if (op_q[3] && !fin_q)
							fault(ERR_PROTOCOL);
						else
							ph = PH_HDR1;
					end
				end
			endcase
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: kind %0d", got.out_kind);
				mismatches++;
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			cmp_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
			cmp_field("fin", 64'(want.fin), 64'(got.fin));
			cmp_field("opcode", 64'(want.opcode), 64'(got.opcode));
			cmp_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
			cmp_field("data_out", 64'(want.data_out), 64'(got.data_out));
			cmp_field("last_of_frame", 64'(want.last_of_frame), 64'(got.last_of_frame));
			cmp_field("error_code", 64'(want.error_code), 64'(got.error_code));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic                  write_en;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] write_data;

	wsfr_byte_if   frame_bytes();
	wsfr_result_if results();

	frame_scoreboard sb = new();
	result_t seen_word;
	bit idle_on;
	bit hold_out;
	int sent_bytes;
	int stall_cycles;

	websocket_frame_receiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_bytes(frame_bytes),
		.results(results),
		.write_en(write_en),
		.reg_index(reg_index),
		.write_data(write_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && frame_bytes.valid && frame_bytes.ready)
			sb.deframe_byte(frame_bytes.data_byte);
	end

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			seen_word.out_kind = kind_t'(results.out_kind);
			seen_word.fin = results.fin;
			seen_word.opcode = results.opcode;
			seen_word.payload_length = results.payload_length;
			seen_word.data_out = results.data_out;
			seen_word.last_of_frame = results.last_of_frame;
			seen_word.error_code = results.error_code;
			sb.check_word(seen_word);
		end
	end

	// result side: short random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_out) begin
				results.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				results.ready <= 1'b1;
				hold_out = 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				results.ready <= 1'b1;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (frame_bytes.valid && frame_bytes.ready) ||
					(results.valid && results.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_byte(input logic [DATA_W-1:0] b);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			frame_bytes.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		frame_bytes.valid <= 1'b1;
		frame_bytes.data_byte <= b;
		@(posedge clk);
		while (!frame_bytes.ready) @(posedge clk);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic fin, input logic [OPCODE_W-1:0] op,
			input logic [63:0] len, input len_enc_t enc);
		send_byte({fin, 3'b000, op});
		case (enc)
			LEN_SHORT: send_byte({1'b1, len[6:0]});
			LEN_EXT16: begin
				send_byte({1'b1, LEN7_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({1'b1, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8*i +: 8]);
			end
		endcase
	endtask

	task automatic send_frame(input logic fin, input logic [OPCODE_W-1:0] op,
			input logic [63:0] len, input len_enc_t enc);
		send_header(fin, op, len, enc);
		repeat (4) send_byte(8'($urandom));
		for (logic [63:0] k = 0; k < len; k++)
			send_byte(8'($urandom));
	endtask

	function automatic logic [63:0] pick_len(input logic [63:0] cap);
		logic [63:0] n;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10 && cap < 64'd300)
			n = cap;
		else if (r < 60)
			n = 64'($urandom_range(0, 8));
		else if (r < 85)
			n = 64'($urandom_range(9, 30));
		else if (r < 97)
			n = 64'($urandom_range(31, 130));
		else
			n = 64'($urandom_range(131, 300));
		return (n > cap) ? cap : n;
	endfunction

	// control frames may only use the length escapes the limit lets through
	function automatic len_enc_t pick_enc(input logic [63:0] len, input bit ctl);
		int widest;
		int r;
		if (!ctl || sb.ctrl_lim == 7'd127)
			widest = 2;
		else if (sb.ctrl_lim == 7'd126)
			widest = 1;
		else
			widest = 0;
		r = $urandom_range(0, 9);
		if (len > 64'd125)
			return (widest == 2 && r < 5) ? LEN_EXT64 : LEN_EXT16;
		if (widest == 0 || r < 6)
			return LEN_SHORT;
		if (widest == 1 || r < 8)
			return LEN_EXT16;
		return LEN_EXT64;
	endfunction

	task automatic send_random_frame();
		logic fin;
		logic [OPCODE_W-1:0] op;
		logic [63:0] cap;
		logic [63:0] len;
		len_enc_t enc;
		int r;
		bit ctl;
		ctl = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 2);
		cap = (sb.max_len < 63'd300) ? {1'b0, sb.max_len} : 64'd300;
		if (ctl) begin
			fin = 1'b1;
			op = (r == 0) ? OP_CLOSE : (r == 1) ? OP_PING : OP_PONG;
			if (sb.ctrl_lim <= 7'd125 && {57'd0, sb.ctrl_lim} < cap)
				cap = {57'd0, sb.ctrl_lim};
		end else begin
			fin = 1'($urandom_range(0, 1));
			op = (r == 0) ? OP_CONT : (r == 1) ? OP_TEXT : OP_BINARY;
		end
		len = pick_len(cap);
		enc = pick_enc(len, ctl);
		send_frame(fin, op, len, enc);
	endtask

	// stop sending and wait for all expected words, then let the pipe settle
	task automatic drain(input int tail);
		frame_bytes.valid <= 1'b0;
		do @(negedge clk); while (sb.pending_results.size() != 0);
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		write_en <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic program_cfg(input logic [LEN_W-1:0] max_len,
			input logic [CTRL_LIM_W-1:0] ctrl, input logic [CFG_IDX_W-1:0] spare);
		logic [CFG_DATA_W-1:0] v;
		write_cfg(CFG_MAX_FRAME_LEN, max_len);
		// junk above the 7-bit limit must be dropped
		v = CFG_DATA_W'({$urandom, $urandom});
		v[CTRL_LIM_W-1:0] = ctrl;
		write_cfg(CFG_CONTROL_LIMIT, v);
		write_cfg(spare, CFG_DATA_W'({$urandom, $urandom}));
		write_en <= 1'b0;
	endtask

	task automatic run_random(input int target, input pressure_t press);
		int start;
		bit done;
		start = sent_bytes;
		done = 1'b0;
		while (sent_bytes - start < target) begin
			if (!done && sent_bytes - start >= target / 2) begin
				done = 1'b1;
				if (press == PRESS_HOLD)
					hold_out = 1'b1;
				else if (press == PRESS_PAUSE)
					drain(0);
			end
			send_random_frame();
		end
	endtask

	// a failure sticks until reset, so only one kind can be hit per run
	task automatic send_fault_case();
		fault_t which;
		logic [LEN_W-1:0] big_max;
		int u;
		which = fault_t'($urandom_range(0, 6));
		u = $urandom_range(0, 9);
		case (which)
			F_RESERVED:
				send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), OP_TEXT});
			F_OPCODE:
				send_byte({1'($urandom_range(0, 1)), 3'b000,
					(u < 5) ? 4'(3 + u) : 4'(6 + u)});
			F_FRAG_CTRL:
				send_byte({1'b0, 3'b000,
					(u < 3) ? OP_CLOSE : (u < 6) ? OP_PING : OP_PONG});
			F_CTRL_LEN: begin
				send_byte({1'b1, 3'b000, OP_PING});
				send_byte({1'($urandom_range(0, 1)),
					7'($urandom_range(int'(sb.ctrl_lim) + 1, 127))});
			end
			F_NO_MASK: begin
				send_byte({1'b1, 3'b000, OP_BINARY});
				send_byte({1'b0, 7'($urandom)});
			end
			F_HUGE:
				send_header(1'($urandom_range(0, 1)), OP_TEXT,
					{1'b1, 63'({$urandom, $urandom})}, LEN_EXT64);
			default: begin
				drain(DRAIN_TAIL);
				big_max = LEN_W'({$urandom, $urandom} >> 2);
				program_cfg(big_max, sb.ctrl_lim, CFG_SPARE_2);
				send_header(1'b1, OP_BINARY,
					{1'b0, big_max} + 64'($urandom_range(1, 1000)), LEN_EXT64);
			end
		endcase
	endtask

	initial begin
		frame_bytes.valid <= 1'b0;
		frame_bytes.data_byte <= '0;
		results.ready <= 1'b0;
		write_en <= 1'b0;
		reg_index <= '0;
		write_data <= '0;
		idle_on = 1'b1;
		hold_out = 1'b0;
		sent_bytes = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty control frame, fragment start, 16-bit length escape
		send_frame(1'b1, OP_PING, 64'd0, LEN_SHORT);
		send_frame(1'b0, OP_TEXT, 64'd3, LEN_SHORT);
		send_frame(1'b1, OP_CONT, 64'd1, LEN_EXT16);

		drain(DRAIN_TAIL);
		program_cfg({LEN_W{1'b1}}, 7'd127, CFG_SPARE_2);
		run_random(150, PRESS_HOLD);

		drain(DRAIN_TAIL);
		program_cfg('0, 7'd0, CFG_SPARE_3);
		idle_on = 1'b0;
		run_random(60, PRESS_NONE);

		drain(DRAIN_TAIL);
		program_cfg(LEN_W'($urandom_range(20, 60)), 7'($urandom_range(0, 125)), CFG_SPARE_2);
		idle_on = 1'b1;
		run_random(150, PRESS_PAUSE);

		drain(DRAIN_TAIL);
		program_cfg(MAX_FRAME_LEN_RST, CONTROL_LIMIT_RST, CFG_SPARE_3);
		idle_on = 1'b0;
		run_random(150, PRESS_NONE);

		send_fault_case();
		repeat ($urandom_range(8, 16)) send_byte(8'($urandom));
		frame_bytes.valid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/wsfr_pkg.sv
rtl/wsfr_byte_if.sv
rtl/wsfr_result_if.sv
rtl/wsfr_parser.sv
rtl/websocket_frame_receiver_unit.sv
tb/testbench.sv
